// ----- hdl/halton_sample_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Halton sample generator assertion macros
// Shared concurrent assertion forms used by the generator RTL.
// ----------------------------------------------------------------------------
`ifndef HALTON_SAMPLE_GENERATOR_DEFINES_SVH
`define HALTON_SAMPLE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define HSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/hsg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halton sample generator package
// Transaction types, control groups and elaboration helpers.
// ----------------------------------------------------------------------------
package hsg_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_BITS_DEF  = 14;

	localparam int PIX_W = 14;
	localparam int CNT_W = 7;
	localparam int OUT_W = 30;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic [CNT_W-1:0] sample_count;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] sample_x;
		logic [OUT_W-1:0] sample_y;
		logic             last;
	} smp_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	typedef struct packed {
		logic clear;
		logic inc;
	} cnt_ctl_t;

	// Number of base-3 digits needed to hold values up to v
	function automatic int base3_digits(input int v);
		int r;
		int p;
		r = 0;
		p = 1;
		while (p <= v) begin
			p = p * 3;
			r = r + 1;
		end
		return r;
	endfunction

	function automatic int pow3(input int e);
		int p;
		p = 1;
		for (int k = 0; k < e; k++) begin
			p = p * 3;
		end
		return p;
	endfunction

endpackage

// ----- hdl/halton_sample_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halton sample generator (bases 2 and 3)
// Emits sample_count points per request, capped at MAX_SAMPLES, at the pixel
// plus the radical inverses of the indices 1..n, in unsigned fixed point.
// ----------------------------------------------------------------------------
//  channel   | ports                  | handshake
//  ----------+------------------------+------------------------------------
//  request   | start, busy, req       | taken when start && !busy
//  sample    | sample_valid, sample   | one-cycle strobe, no back-pressure
//
//  For each sample the fraction unit makes one bit per cycle in the divide
//  state, then a handoff state strobes the sample and reloads the unit.
//  A request with n > 0 holds busy through the load state and every sample;
//  a count of zero is taken without raising busy.
//  The final strobe shows in the first cycle busy is low again.
//  arst_n clears the sequencer and the strobe; payload holds no reset.
// ----------------------------------------------------------------------------
`include "halton_sample_generator_defines.svh"

module halton_sample_generator #(
	parameter int MAX_SAMPLES = hsg_pkg::MAX_SAMPLES_DEF,
	parameter int FRAC_BITS   = hsg_pkg::FRAC_BITS_DEF,
	parameter int COORD_BITS  = hsg_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hsg_pkg::req_t req,
	output logic          sample_valid,
	output hsg_pkg::smp_t sample
);

	localparam int PW     = hsg_pkg::PIX_W;
	localparam int CW     = hsg_pkg::CNT_W;
	localparam int OW     = hsg_pkg::OUT_W;
	localparam int ND3    = hsg_pkg::base3_digits(MAX_SAMPLES);
	localparam int DEN_W  = $clog2(hsg_pkg::pow3(ND3) + 1);
	localparam int IDX_W  = $clog2(MAX_SAMPLES + 1);
	localparam int STEP_W = $clog2(FRAC_BITS);

	localparam logic [PW-1:0]     CMASK     = PW'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [CW-1:0]     MAX_CNT   = CW'(MAX_SAMPLES);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_BITS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [PW-1:0]       px_q;
	logic [PW-1:0]       py_q;
	logic [IDX_W-1:0]    n_q;
	logic [IDX_W-1:0]    idx_q;
	logic [STEP_W-1:0]   step_q;
	logic                last_q;
	logic                valid_q;
	hsg_pkg::smp_t       sample_q;

	logic                accept;
	logic [IDX_W-1:0]    n_sat;
	logic                step_end;
	hsg_pkg::div_ctl_t   div_ctl;
	hsg_pkg::cnt_ctl_t   cnt_ctl;
	logic [DEN_W-1:0]    num;
	logic [DEN_W-1:0]    den;
	logic [FRAC_BITS-1:0] frac2;
	logic [FRAC_BITS-1:0] frac3;
	logic [63:0]         wide_x;
	logic [63:0]         wide_y;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign n_sat    = (req.sample_count > MAX_CNT) ? IDX_W'(MAX_CNT) : IDX_W'(req.sample_count);
	assign step_end = (state_q == ST_DIV) && (step_q == STEP_LAST);

	assign cnt_ctl.clear = accept && (n_sat != '0);
	assign cnt_ctl.inc   = step_end && (idx_q != n_q);
	assign div_ctl.load  = (state_q == ST_LOAD) || ((state_q == ST_FIN) && !last_q);
	assign div_ctl.step  = (state_q == ST_DIV);

	hsg_digit_ctr #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.DEN_W      (DEN_W)
	) u_digit_ctr (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cnt_ctl),
		.num   (num),
		.den   (den)
	);

	hsg_serial_div #(
		.FRAC_BITS(FRAC_BITS),
		.DEN_W    (DEN_W),
		.IDX_W    (IDX_W)
	) u_serial_div (
		.clk  (clk),
		.ctl  (div_ctl),
		.num  (num),
		.den  (den),
		.idx  (idx_q),
		.frac2(frac2),
		.frac3(frac3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (n_sat != '0)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_end) begin
						last_q  <= (idx_q == n_q);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					step_q  <= '0;
					state_q <= last_q ? ST_IDLE : ST_DIV;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields and index
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q  <= req.pixel_x & CMASK;
			py_q  <= req.pixel_y & CMASK;
			n_q   <= n_sat;
			idx_q <= IDX_W'(1);
		end else if (cnt_ctl.inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Fraction is below one, so the add reduces to placing it under the pixel
	assign wide_x = (64'(px_q) << FRAC_BITS) | 64'(frac2);
	assign wide_y = (64'(py_q) << FRAC_BITS) | 64'(frac3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			sample_q.sample_x <= wide_x[OW-1:0];
			sample_q.sample_y <= wide_y[OW-1:0];
			sample_q.last     <= last_q;
		end
	end

	assign sample_valid = valid_q;
	assign sample       = sample_q;

	`HSG_ASSERT_NEXT(a_fin_strobes, clk, arst_n, state_q == ST_FIN, sample_valid,
		"handoff state did not produce a sample strobe")
	`HSG_ASSERT_NOW(a_strobe_from_fin, clk, arst_n, sample_valid, $past(state_q == ST_FIN),
		"sample strobe without a preceding handoff")
	`HSG_ASSERT_NOW(a_last_frees, clk, arst_n, sample_valid && sample.last,
		state_q == ST_IDLE, "final sample shown while still busy")
	`HSG_ASSERT_NOW(a_idx_range, clk, arst_n, state_q != ST_IDLE,
		(idx_q != '0) && (idx_q <= n_q), "sample index left 1..n during a request")

endmodule

// ----- hdl/hsg_digit_ctr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-3 index counter
// Holds the sample index as base-3 digits and presents the digit-reversed
// numerator and the power-of-three denominator of its radical inverse.
// ----------------------------------------------------------------------------
module hsg_digit_ctr #(
	parameter int MAX_SAMPLES = hsg_pkg::MAX_SAMPLES_DEF,
	parameter int DEN_W       = $clog2(hsg_pkg::pow3(hsg_pkg::base3_digits(MAX_SAMPLES)) + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hsg_pkg::cnt_ctl_t       ctl,
	output logic [DEN_W-1:0]        num,
	output logic [DEN_W-1:0]        den
);

	localparam int ND3 = hsg_pkg::base3_digits(MAX_SAMPLES);

	logic [1:0]     dig_q [ND3];
	logic [1:0]     dig_d [ND3];
	logic [ND3-1:0] act;

	// Ripple a +1 through the digits
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int k = 0; k < ND3; k++) begin
			dig_d[k] = dig_q[k];
			if (carry) begin
				if (dig_q[k] == 2'd2) begin
					dig_d[k] = 2'd0;
				end else begin
					dig_d[k] = dig_q[k] + 2'd1;
					carry    = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ND3; k++) begin
				dig_q[k] <= 2'd0;
			end
		end else if (ctl.clear) begin
			for (int k = 0; k < ND3; k++) begin
				dig_q[k] <= (k == 0) ? 2'd1 : 2'd0;
			end
		end else if (ctl.inc) begin
			for (int k = 0; k < ND3; k++) begin
				dig_q[k] <= dig_d[k];
			end
		end
	end

	// Mark digits at or below the leading nonzero one
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int k = ND3 - 1; k >= 0; k--) begin
			seen   = seen | (dig_q[k] != 2'd0);
			act[k] = seen;
		end
	end

	// Reverse the digits into the numerator, scale the denominator to match
	always_comb begin
		num = '0;
		den = DEN_W'(1);
		for (int k = 0; k < ND3; k++) begin
			if (act[k]) begin
				num = DEN_W'({num, 1'b0}) + num + DEN_W'(dig_q[k]);
				den = DEN_W'({den, 1'b0}) + den;
			end
		end
	end

endmodule

// ----- hdl/hsg_serial_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial fraction unit
// Produces one fraction bit per step for both axes: a restoring divider for
// the base-3 inverse and a bit-reversing shifter for the base-2 inverse.
// ----------------------------------------------------------------------------
module hsg_serial_div #(
	parameter int FRAC_BITS = hsg_pkg::FRAC_BITS_DEF,
	parameter int DEN_W     = 7,
	parameter int IDX_W     = 7
) (
	input  logic                 clk,
	input  hsg_pkg::div_ctl_t    ctl,
	input  logic [DEN_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	input  logic [IDX_W-1:0]     idx,
	output logic [FRAC_BITS-1:0] frac2,
	output logic [FRAC_BITS-1:0] frac3
);

	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [IDX_W-1:0]     bits_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [FRAC_BITS-1:0] rev_q;

	logic [DEN_W:0]   twice;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [DEN_W-1:0] rem_d;

	assign twice = {rem_q, 1'b0};
	assign diff  = twice - {1'b0, den_q};
	assign ge    = (twice >= {1'b0, den_q});
	assign rem_d = ge ? diff[DEN_W-1:0] : twice[DEN_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= num;
			den_q  <= den;
			bits_q <= idx;
			quo_q  <= '0;
			rev_q  <= '0;
		end else if (ctl.step) begin
			rem_q  <= rem_d;
			quo_q  <= {quo_q[FRAC_BITS-2:0], ge};
			// index bits leave LSB first and land MSB first
			rev_q  <= {rev_q[FRAC_BITS-2:0], bits_q[0]};
			bits_q <= bits_q >> 1;
		end
	end

	assign frac2 = rev_q;
	assign frac3 = quo_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halton sample generator testbench
// Drives pixel requests through the start/busy handshake and checks every
// sample strobe against a local computation of the base-2 and base-3
// radical inverses, truncated to the fixed-point fraction width.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_SAMPLES = hsg_pkg::MAX_SAMPLES_DEF;
	localparam int FRAC_BITS   = hsg_pkg::FRAC_BITS_DEF;
	localparam int COORD_BITS  = hsg_pkg::COORD_BITS_DEF;
	localparam int PIX_W       = hsg_pkg::PIX_W;
	localparam int CNT_W       = hsg_pkg::CNT_W;
	localparam int RANDOM_REQS = 244;
	localparam int STEADY_TAIL = 40;
	localparam int TAIL_CYCLES = 2 * (FRAC_BITS + 1) + 8;
	localparam longint CYCLE_LIMIT = 5000000;

	typedef struct {
		hsg_pkg::req_t r;
		bit            drain;   // wait for every outstanding sample first
		bit            steady;  // no idle cycles before this request
	} pend_req_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	hsg_pkg::req_t req;
	logic          sample_valid;
	hsg_pkg::smp_t sample;

	pend_req_t     pending_reqs[$];
	hsg_pkg::smp_t expected_samples[$];
	logic          req_taken;
	int            gap_left;
	int            error_count;
	longint        cycle_count;

	halton_sample_generator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.sample_valid (sample_valid),
		.sample       (sample)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// floor(radical_inverse(idx) * 2^FRAC_BITS), exact in integers
	function automatic longint unsigned radical_fraction(input int unsigned idx,
			input int unsigned base);
		longint unsigned num;
		longint unsigned den;
		int unsigned     k;
		num = 0;
		den = 1;
		k = idx;
		while (k > 0) begin
			num = num * base + (k % base);
			den = den * base;
			k = k / base;
		end
		return (num << FRAC_BITS) / den;
	endfunction

	function automatic void predict_samples(input hsg_pkg::req_t r);
		longint unsigned px;
		longint unsigned py;
		longint unsigned sx;
		longint unsigned sy;
		int unsigned     n;
		hsg_pkg::smp_t   s;
		px = r.pixel_x & ((64'd1 << COORD_BITS) - 1);
		py = r.pixel_y & ((64'd1 << COORD_BITS) - 1);
		n = r.sample_count;
		if (n > MAX_SAMPLES)
			n = MAX_SAMPLES;
		for (int unsigned i = 1; i <= n; i++) begin
			sx = (px << FRAC_BITS) + radical_fraction(i, 2);
			sy = (py << FRAC_BITS) + radical_fraction(i, 3);
			s.sample_x = sx[hsg_pkg::OUT_W-1:0];
			s.sample_y = sy[hsg_pkg::OUT_W-1:0];
			s.last = (i == n);
			expected_samples.push_back(s);
		end
	endfunction

	function automatic void queue_req(input int px, input int py, input int cnt,
			input bit drain, input bit steady);
		pend_req_t p;
		p.r.pixel_x = PIX_W'(px);
		p.r.pixel_y = PIX_W'(py);
		p.r.sample_count = CNT_W'(cnt);
		p.drain = drain;
		p.steady = steady;
		pending_reqs.push_back(p);
	endfunction

	function automatic int rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 0;
		else if (sel == 1)
			return (1 << hsg_pkg::PIX_W) - 1;
		return $urandom_range(0, (1 << hsg_pkg::PIX_W) - 1);
	endfunction

	// Mostly short requests; some zero counts and a few full-length and saturating ones
	function automatic int rand_count();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return 0;
		else if (sel < 75)
			return $urandom_range(1, 8);
		else if (sel < 90)
			return $urandom_range(9, 40);
		else if (sel < 95)
			return $urandom_range(41, MAX_SAMPLES);
		return $urandom_range(MAX_SAMPLES + 1, (1 << hsg_pkg::CNT_W) - 1);
	endfunction

	// Driver: present one request at a time, change inputs on the falling edge
	always @(negedge clk) begin
		logic          nxt_start;
		hsg_pkg::req_t nxt_req;
		pend_req_t     p;
		nxt_start = start;
		nxt_req = req;
		if (arst_n && (!start || req_taken)) begin
			nxt_start = 1'b0;
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
			end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain && (expected_samples.size() != 0 || busy))) begin
				if (!pending_reqs[0].steady && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 3);
				end else begin
					p = pending_reqs.pop_front();
					nxt_start = 1'b1;
					nxt_req = p.r;
				end
			end
		end
		start <= nxt_start;
		req <= nxt_req;
	end

	// Monitor: check strobed samples, then predict for an accepted request
	always @(posedge clk or negedge arst_n) begin
		hsg_pkg::smp_t exp_s;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (sample_valid) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample x=%h y=%h last=%b", $realtime,
						sample.sample_x, sample.sample_y, sample.last);
					error_count++;
				end else begin
					exp_s = expected_samples.pop_front();
					if (sample.sample_x !== exp_s.sample_x) begin
						$display("%0t: sample_x expected %h actual %h", $realtime,
							exp_s.sample_x, sample.sample_x);
						error_count++;
					end
					if (sample.sample_y !== exp_s.sample_y) begin
						$display("%0t: sample_y expected %h actual %h", $realtime,
							exp_s.sample_y, sample.sample_y);
						error_count++;
					end
					if (sample.last !== exp_s.last) begin
						$display("%0t: last expected %b actual %b", $realtime,
							exp_s.last, sample.last);
						error_count++;
					end
				end
			end
			if (start && !busy)
				predict_samples(req);
			req_taken <= start && !busy;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		start = 1'b0;
		req = '0;
		gap_left = 0;
		error_count = 0;
		cycle_count = 0;

		// Directed: extremes, zero counts, saturation, digit rollovers
		queue_req(0, 0, 1, 1'b0, 1'b0);
		queue_req(16383, 16383, 64, 1'b0, 1'b0);
		queue_req(0, 16383, 0, 1'b0, 1'b0);
		queue_req(16383, 0, 0, 1'b0, 1'b1);
		queue_req(5, 7, 0, 1'b0, 1'b1);
		queue_req(16383, 0, 127, 1'b0, 1'b0);
		queue_req(10922, 5461, 65, 1'b1, 1'b0);
		queue_req(5461, 10922, 2, 1'b0, 1'b1);
		queue_req(1, 1, 3, 1'b0, 1'b1);
		queue_req(8191, 8192, 9, 1'b0, 1'b0);
		queue_req(100, 200, 27, 1'b0, 1'b0);
		queue_req(16382, 1, 63, 1'b0, 1'b0);
		queue_req(0, 0, 0, 1'b0, 1'b0);
		queue_req(12345, 6789, 8, 1'b1, 1'b0);
		queue_req(16383, 16383, 1, 1'b0, 1'b1);
		queue_req(4096, 2048, 16, 1'b0, 1'b0);

		// Keep drain pauses out of the steady tail
		for (int k = 0; k < RANDOM_REQS; k++)
			queue_req(rand_coord(), rand_coord(), rand_count(),
				(k < RANDOM_REQS - STEADY_TAIL) && ($urandom_range(0, 39) == 0),
				k >= RANDOM_REQS - STEADY_TAIL);

		wait (arst_n === 1'b1);
		while (pending_reqs.size() != 0 || start)
			@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
